@@ rtl/wza_pkg.sv @@
// Shared constants, codes and helpers for the windowed z-score anomaly block.
package wza_pkg;

  // Defaults of the top-level parameters
  localparam int DEF_NUM_METRICS = 16;
  localparam int DEF_WINDOW      = 20;
  localparam int DEF_VALUE_BITS  = 32;

  // Operation codes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  // Register indexes (paddr[2]) and reset values
  localparam logic       REG_MIN_HIST  = 1'b0;
  localparam logic       REG_THRESHOLD = 1'b1;
  localparam logic [4:0] MIN_HIST_RST  = 5'd5;
  localparam logic [9:0] THRESHOLD_RST = 10'd800;
  localparam int         APB_AW        = 3;

  // Score search range and scale factors
  localparam logic [9:0]  SCORE_MAX = 10'd1000;
  localparam int          SCALE_W   = 20;
  localparam logic [19:0] SCALE     = 20'd1000000;
  localparam int          K2_W      = 24;

  // Digit width of the shared shift-add multiplier
  localparam int MUL_DIG = 16;

  // 9*k^2 for a score candidate k
  function automatic logic [K2_W-1:0] k2_of(input logic [9:0] k);
    logic [19:0] sq;
    sq = k * k;
    return {1'b0, sq, 3'b000} + {4'b0000, sq};
  endfunction

endpackage

@@ rtl/wza_mul.sv @@
// Digit-serial multiplier: one 16-bit digit of b per cycle, truncated to A_W bits.
module wza_mul
  import wza_pkg::*;
#(
  parameter int A_W = 96,
  parameter int B_W = 37
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic           done,
  output logic [A_W-1:0] prod
);

  logic [A_W-1:0] a_sh;
  logic [B_W-1:0] b_sh;
  logic [B_W-1:0] b_rest;
  logic [A_W-1:0] part;
  logic           run;

  assign part   = A_W'(a_sh * b_sh[MUL_DIG-1:0]);
  assign b_rest = b_sh >> MUL_DIG;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        a_sh <= a;
        b_sh <= b;
        prod <= '0;
        run  <= 1'b1;
      end else if (run) begin
        // add this digit's partial product, advance to the next digit
        prod <= prod + part;
        a_sh <= a_sh << MUL_DIG;
        b_sh <= b_rest;
        if (b_rest == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run))
    else $error("multiplier done without a running product");
  a_go_starts: assert property (@(posedge clk) disable iff (rst)
    go |=> run)
    else $error("multiplier did not start");
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (run && !go) |=> (run || done))
    else $error("multiplier stopped without done");

endmodule

@@ rtl/windowed_zscore_anomaly_top.sv @@
// Top level of the windowed z-score anomaly detector.
//
// Usage: an item is taken on the rising edge where start is high and busy is
// low. operation selects record (append sample_value to the metric's ring of
// its WINDOW latest samples) or check (score sample_value against the ring).
// Every item gives exactly one result word: done is high for one cycle with
// anomaly, score, enough_history and anomaly_seq; the receiver cannot stall,
// so the word must be taken in that cycle.
// A record, an out-of-range metric or a check with too little history ends
// after the metadata step. A full check for a window of n samples does n
// reads from the sample memory and drains the square/accumulate pipeline,
// then three wide products, about ten score-search steps and, if the threshold
// is below SCORE_MAX, one threshold product, all on one digit-serial
// multiplier (16 bits of the short operand per cycle).
// One item is worked at a time; busy stays high until its result word shows.
// Configuration (APB, pready tied high): min_history at byte 0, score
// threshold at byte 4; write only while busy is low.
// Reset clears the per-metric fill/slot valid bits, the anomaly counter and
// the registers to their defaults; the sample memory holds no reset value and
// is never read before written.
module windowed_zscore_anomaly_top
  import wza_pkg::*;
#(
  parameter int NUM_METRICS = DEF_NUM_METRICS,
  parameter int WINDOW      = DEF_WINDOW,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              operation,
  input  logic [3:0]        metric_id,
  input  logic signed [31:0] sample_value,
  output logic              done,
  output logic              anomaly,
  output logic [9:0]        score,
  output logic              enough_history,
  output logic [15:0]       anomaly_seq,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int NB     = $clog2(WINDOW + 1);
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int MI_W   = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
  localparam int ID_X   = (MI_W > 4) ? MI_W : 4;
  localparam int DEPTH  = NUM_METRICS * WINDOW;
  localparam int AW     = $clog2(DEPTH);
  localparam int VB     = VALUE_BITS;
  localparam int SW     = VB + NB;
  localparam int DW     = SW + 1;
  localparam int DM_W   = SW;
  localparam int QW     = 2 * VB - 2 + NB;
  localparam int VW     = QW + NB;
  localparam int LW     = 2 * DM_W + SCALE_W;
  localparam int RW     = VW + K2_W;
  localparam int CW     = (LW > RW) ? LW : RW;
  localparam int MB_W   = (DM_W > K2_W) ? DM_W : K2_W;
  localparam int MT_W   = NB + SLOT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_META = 4'd1;
  localparam logic [3:0] S_READ = 4'd2;
  localparam logic [3:0] S_CALC = 4'd3;
  localparam logic [3:0] S_SS   = 4'd4;
  localparam logic [3:0] S_DD   = 4'd5;
  localparam logic [3:0] S_E6   = 4'd6;
  localparam logic [3:0] S_K2   = 4'd7;
  localparam logic [3:0] S_KMUL = 4'd8;
  localparam logic [3:0] S_TMUL = 4'd9;

  logic [3:0] state;

  // configuration registers
  logic [4:0] min_hist;
  logic [9:0] thr;

  // latched item
  logic            op_q;
  logic [MI_W-1:0] idx_q;
  logic            inr_q;
  logic [VB-1:0]   x_q;
  logic [AW-1:0]   base_q;

  // per-metric fill count and write slot
  logic [MT_W-1:0] meta_mem [NUM_METRICS];
  logic [NUM_METRICS-1:0] meta_valid;
  logic [MT_W-1:0] meta_q;
  logic            meta_vq;

  // sample ring memory
  logic [VB-1:0] smp_mem [DEPTH];
  logic [VB-1:0] smp_q;
  logic [AW-1:0] smp_ra;
  logic [AW-1:0] smp_wa;
  logic          smp_we;

  // window accumulation
  logic [NB-1:0]        n_q;
  logic [NB-1:0]        rd_cnt;
  logic                 rd_go;
  logic                 p1, p2, p3;
  logic [VB-1:0]        mag_q;
  logic [2*VB-1:0]      sq_q;
  logic signed [SW-1:0] s_acc;
  logic [QW-1:0]        q_acc;

  // products and score search
  logic [VW-1:0] nq_q;
  logic [VW-1:0] ss_q;
  logic [VW-1:0] var_q;
  logic [DM_W-1:0] dm_q;
  logic [CW-1:0] lhs_q;
  logic [9:0]    lo, hi, mid_q;
  logic [15:0]   counter;

  logic            mul_go;
  logic [CW-1:0]   mul_a;
  logic [MB_W-1:0] mul_b;
  logic            mul_done;
  logic [CW-1:0]   mul_prod;

  // combinational helpers
  logic                 accept;
  logic [ID_X-1:0]      id_ext;
  logic [MI_W-1:0]      idx_in;
  logic [NB-1:0]        fill_c, fill_nx;
  logic [SLOT_W-1:0]    slot_c, slot_nx;
  logic signed [SW-1:0] xs_c;
  logic [VB-1:0]        mag_c;
  logic signed [DW-1:0] x_ext, nx_c, d_c;
  logic [DM_W-1:0]      dm_c, sm_c;
  logic [9:0]           mid_c;
  logic                 prod_le;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_HIST) ? {27'd0, min_hist} : {22'd0, thr};

  assign id_ext = ID_X'(metric_id);
  assign idx_in = id_ext[MI_W-1:0];

  assign fill_c  = meta_vq ? meta_q[MT_W-1:SLOT_W] : '0;
  assign slot_c  = meta_vq ? meta_q[SLOT_W-1:0] : '0;
  assign slot_nx = (slot_c == SLOT_W'(WINDOW - 1)) ? '0 : slot_c + 1'b1;
  assign fill_nx = (fill_c < NB'(WINDOW)) ? fill_c + 1'b1 : fill_c;

  assign rd_go  = (state == S_READ) && (rd_cnt != n_q);
  assign smp_ra = base_q + AW'(rd_cnt);
  assign smp_wa = base_q + AW'(slot_c);
  assign smp_we = (state == S_META) && inr_q && (op_q == OP_RECORD);

  assign xs_c  = SW'(signed'(smp_q));
  assign mag_c = smp_q[VB-1] ? VB'(-smp_q) : smp_q;
  assign x_ext = DW'(signed'(x_q));
  assign nx_c  = DW'(signed'({1'b0, n_q}) * x_ext);
  assign d_c   = nx_c - DW'(s_acc);
  assign dm_c  = d_c[DW-1] ? DM_W'(-d_c) : DM_W'(d_c);
  assign sm_c  = s_acc[SW-1] ? DM_W'(-s_acc) : DM_W'(s_acc);
  assign mid_c = 10'((11'(lo) + 11'(hi) + 11'd1) >> 1);
  assign prod_le = (mul_prod <= lhs_q);

  wza_mul #(.A_W(CW), .B_W(MB_W)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  // sample memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (smp_we) begin
      smp_mem[smp_wa] <= x_q;
    end
    smp_q <= smp_mem[smp_ra];
  end

  // metadata memory: read on accept, write back in the record step
  always_ff @(posedge clk) begin
    if (smp_we) begin
      meta_mem[idx_q] <= {fill_nx, slot_nx};
    end
    if (accept) begin
      meta_q <= meta_mem[idx_in];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_hist <= MIN_HIST_RST;
      thr      <= THRESHOLD_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_MIN_HIST) begin
        min_hist <= pwdata[4:0];
      end else begin
        thr <= pwdata[9:0];
      end
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      mul_go     <= 1'b0;
      meta_valid <= '0;
      counter    <= '0;
      p1         <= 1'b0;
      p2         <= 1'b0;
      p3         <= 1'b0;
    end else begin
      done   <= 1'b0;
      mul_go <= 1'b0;
      p1     <= rd_go;
      p2     <= p1;
      p3     <= p2;
      if (p1) begin
        s_acc <= s_acc + xs_c;
        mag_q <= mag_c;
      end
      if (p2) begin
        sq_q <= mag_q * mag_q;
      end
      if (p3) begin
        q_acc <= q_acc + QW'(sq_q);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q           <= operation;
            idx_q          <= idx_in;
            inr_q          <= (32'(metric_id) < NUM_METRICS);
            x_q            <= sample_value[VB-1:0];
            base_q         <= AW'(idx_in * WINDOW);
            meta_vq        <= meta_valid[idx_in];
            anomaly        <= 1'b0;
            score          <= '0;
            enough_history <= 1'b0;
            anomaly_seq    <= '0;
            state          <= S_META;
          end
        end
        S_META: begin
          n_q    <= fill_c;
          rd_cnt <= '0;
          s_acc  <= '0;
          q_acc  <= '0;
          if (!inr_q) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (op_q == OP_RECORD) begin
            meta_valid[idx_q] <= 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (32'(fill_c) < 32'(min_hist)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (32'(fill_c) < 2) begin
            enough_history <= 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            enough_history <= 1'b1;
            state <= S_READ;
          end
        end
        S_READ: begin
          // issue one read a cycle, then drain the accumulate pipeline
          if (rd_go) begin
            rd_cnt <= rd_cnt + 1'b1;
          end else if (!p1 && !p2 && !p3) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          nq_q   <= VW'(q_acc * n_q);
          dm_q   <= dm_c;
          mul_a  <= CW'(sm_c);
          mul_b  <= MB_W'(sm_c);
          mul_go <= 1'b1;
          state  <= S_SS;
        end
        S_SS: begin
          if (mul_done) begin
            ss_q   <= mul_prod[VW-1:0];
            mul_a  <= CW'(dm_q);
            mul_b  <= MB_W'(dm_q);
            mul_go <= 1'b1;
            state  <= S_DD;
          end
        end
        S_DD: begin
          var_q <= nq_q - ss_q;
          if (mul_done) begin
            mul_a  <= mul_prod;
            mul_b  <= MB_W'(SCALE);
            mul_go <= 1'b1;
            state  <= S_E6;
          end
        end
        S_E6: begin
          if (mul_done) begin
            lhs_q <= mul_prod;
            lo    <= '0;
            hi    <= SCORE_MAX;
            if (var_q == '0) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_K2;
            end
          end
        end
        S_K2: begin
          if (lo < hi) begin
            mid_q  <= mid_c;
            mul_a  <= CW'(var_q);
            mul_b  <= MB_W'(k2_of(mid_c));
            mul_go <= 1'b1;
            state  <= S_KMUL;
          end else begin
            score <= lo;
            if (thr < SCORE_MAX) begin
              mul_a  <= CW'(var_q);
              mul_b  <= MB_W'(k2_of(thr));
              mul_go <= 1'b1;
              state  <= S_TMUL;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_KMUL: begin
          if (mul_done) begin
            if (prod_le) begin
              lo <= mid_q;
            end else begin
              hi <= mid_q - 1'b1;
            end
            state <= S_K2;
          end
        end
        S_TMUL: begin
          if (mul_done) begin
            if (!prod_le) begin
              anomaly     <= 1'b1;
              anomaly_seq <= counter + 1'b1;
              counter     <= counter + 1'b1;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word shown while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");
  a_no_history: assert property (@(posedge clk) disable iff (rst)
    (done && !enough_history) |-> (score == '0 && !anomaly && anomaly_seq == '0))
    else $error("score reported without enough history");
  a_seq_counter: assert property (@(posedge clk) disable iff (rst)
    (done && anomaly) |-> (anomaly_seq == counter))
    else $error("anomaly sequence number out of step");

endmodule
